// ===== hdl/krt_pkg.sv =====
// shared constants, codes and struct types for the keyed record table
package krt_pkg;

    localparam int CAPACITY   = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int REQ_W      = 3;
    localparam int KEY_W      = 20;
    localparam int VAL_W      = 9;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = 5;
    localparam int CAP_W      = 6;
    localparam int SUM_W      = VAL_W + CNT_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CAP_W-1:0]      CAP_RESET   = 6'd32;
    localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = 1'b0;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 3'd0,
        REQ_REMOVE    = 3'd1,
        REQ_UPDATE    = 3'd2,
        REQ_LOOKUP    = 3'd3,
        REQ_LIST_ALL  = 3'd4,
        REQ_LIST_MIN  = 3'd5,
        REQ_LIST_MAX  = 3'd6,
        REQ_AVERAGE   = 3'd7
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NONE     = 3'd4
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_key;
        logic [VAL_W-1:0]  wr_val;
    } mem_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } mem_rdata_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== hdl/krt_if.sv =====
// request and result channel interfaces
interface krt_req_if;
    logic                           valid;
    logic                           ready;
    logic [krt_pkg::REQ_W-1:0]      req_type;
    logic [krt_pkg::KEY_W-1:0]      key;
    logic [krt_pkg::VAL_W-1:0]      value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

interface krt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [krt_pkg::STATUS_W-1:0]   status;
    logic [krt_pkg::ENTRY_W-1:0]    entry_index;
    logic [krt_pkg::KEY_W-1:0]      result_key;
    logic [krt_pkg::VAL_W-1:0]      result_value;
    logic                           last;

    modport source (output valid, output status, output entry_index, output result_key,
                    output result_value, output last, input ready);
    modport sink (input valid, input status, input entry_index, input result_key,
                  input result_value, input last, output ready);
endinterface

// ===== hdl/keyed_record_table_top.sv =====
// keyed record table: apb capacity register, sequencer, record memory and divider
// find-type requests scan entries until the hit; remove then shifts each later entry down;
// list and average scan all n entries, and average adds a serial divide
// one item at a time: the scan reads one memory entry per cycle through the single read port,
// unless a list hit is waiting for the output register to free
// reset clears the entry count, the sequencer and the output valid flag; capacity resets to 32
module keyed_record_table_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [krt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [krt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [krt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    krt_req_if.sink                          req,
    krt_rsp_if.source                        rsp
);

    logic [krt_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic                      reg_sel;
    krt_pkg::mem_req_t         mem_req;
    krt_pkg::mem_rdata_t       mem_rdata;
    krt_pkg::div_req_t         div_req;
    krt_pkg::div_rsp_t         div_rsp;

    assign reg_sel = (paddr[krt_pkg::APB_ADDR_W-1:2] == krt_pkg::REG_CAPACITY);

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            cap_next = pwdata[krt_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= krt_pkg::CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_sel ? krt_pkg::APB_DATA_W'(cap_reg) : '0;

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_reg),
        .req       (req),
        .rsp       (rsp),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    krt_store u_store (
        .clk       (clk),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    krt_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule

// ===== hdl/krt_store.sv =====
// key and value record memory, one write port and one registered read port
module krt_store (
    input  logic                clk,
    input  krt_pkg::mem_req_t   mem_req,
    output krt_pkg::mem_rdata_t mem_rdata
);

    logic [krt_pkg::KEY_W-1:0] key_mem [krt_pkg::CAPACITY];
    logic [krt_pkg::VAL_W-1:0] val_mem [krt_pkg::CAPACITY];
    krt_pkg::mem_rdata_t       rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            key_mem[mem_req.wr_addr] <= mem_req.wr_key;
            val_mem[mem_req.wr_addr] <= mem_req.wr_val;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg.key   <= key_mem[mem_req.rd_addr];
        rdata_reg.value <= val_mem[mem_req.rd_addr];
    end

    assign mem_rdata = rdata_reg;

endmodule

// ===== hdl/krt_divider.sv =====
// restoring divider, one quotient bit per cycle
module krt_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  krt_pkg::div_req_t div_req,
    output krt_pkg::div_rsp_t div_rsp
);

    logic [krt_pkg::CNT_W-1:0]     rem_reg, rem_next;
    logic [krt_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [krt_pkg::CNT_W-1:0]     dsr_reg, dsr_next;
    logic [krt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [krt_pkg::CNT_W:0]       shifted;
    logic [krt_pkg::CNT_W:0]       diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[krt_pkg::SUM_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        if (div_req.start)
        begin
            rem_next = '0;
            quo_next = div_req.dividend;
            dsr_next = div_req.divisor;
            cnt_next = krt_pkg::DIV_CNT_W'(krt_pkg::SUM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (!diff[krt_pkg::CNT_W])
            begin
                rem_next = diff[krt_pkg::CNT_W-1:0];
                quo_next = {quo_reg[krt_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[krt_pkg::CNT_W-1:0];
                quo_next = {quo_reg[krt_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - krt_pkg::DIV_CNT_W'(1);
            // final bit lands this cycle
            done_next = (cnt_reg == krt_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

// ===== hdl/krt_ctrl.sv =====
// request sequencer: linear scan, shift-down on remove, sum and result staging
module krt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [krt_pkg::CAP_W-1:0]    cap,
    krt_req_if.sink                      req,
    krt_rsp_if.source                    rsp,
    output krt_pkg::mem_req_t            mem_req,
    input  krt_pkg::mem_rdata_t          mem_rdata,
    output krt_pkg::div_req_t            div_req,
    input  krt_pkg::div_rsp_t            div_rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_TEST   = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_DIVIDE = 6'b010000,
        S_REPLY  = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    krt_pkg::req_type_t              op_reg, op_next;
    logic [krt_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [krt_pkg::VAL_W-1:0]       val_reg, val_next;
    logic [krt_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [krt_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [krt_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic                            held_reg, held_next;
    krt_pkg::status_t                st_status_reg, st_status_next;
    logic [krt_pkg::ENTRY_W-1:0]     st_idx_reg, st_idx_next;
    logic [krt_pkg::KEY_W-1:0]       st_key_reg, st_key_next;
    logic [krt_pkg::VAL_W-1:0]       st_val_reg, st_val_next;
    logic                            out_valid_reg, out_valid_next;
    krt_pkg::status_t                out_status_reg, out_status_next;
    logic [krt_pkg::ENTRY_W-1:0]     out_idx_reg, out_idx_next;
    logic [krt_pkg::KEY_W-1:0]       out_key_reg, out_key_next;
    logic [krt_pkg::VAL_W-1:0]       out_val_reg, out_val_next;
    logic                            out_last_reg, out_last_next;

    logic                            out_free;
    logic                            emit;
    logic                            emit_last;
    logic [krt_pkg::CNT_W-1:0]       idx_inc;
    logic [krt_pkg::CNT_W-1:0]       idx_inc2;
    logic                            scan_end;
    logic                            key_hit;
    logic                            list_hit;
    logic                            is_list;
    logic                            table_full;
    krt_pkg::req_type_t              in_op;

    assign out_free = !out_valid_reg || rsp.ready;
    assign idx_inc  = idx_reg + krt_pkg::CNT_W'(1);
    assign idx_inc2 = idx_reg + krt_pkg::CNT_W'(2);
    assign scan_end = (idx_reg == count_reg);
    assign key_hit  = (mem_rdata.key == key_reg);
    assign is_list  = (op_reg == krt_pkg::REQ_LIST_ALL) || (op_reg == krt_pkg::REQ_LIST_MIN)
                      || (op_reg == krt_pkg::REQ_LIST_MAX);
    assign list_hit = (op_reg == krt_pkg::REQ_LIST_ALL)
                      || ((op_reg == krt_pkg::REQ_LIST_MIN) && (mem_rdata.value >= val_reg))
                      || ((op_reg == krt_pkg::REQ_LIST_MAX) && (mem_rdata.value <= val_reg));
    // effective capacity saturates at the table depth
    assign table_full = (int'(count_reg) >= int'(cap)) || (int'(count_reg) >= krt_pkg::CAPACITY);
    assign in_op      = krt_pkg::req_type_t'(req.req_type);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        held_next       = held_reg;
        st_status_next  = st_status_reg;
        st_idx_next     = st_idx_reg;
        st_key_next     = st_key_reg;
        st_val_next     = st_val_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        mem_req.rd_addr = idx_reg[krt_pkg::ADDR_W-1:0];
        mem_req.we      = 1'b0;
        mem_req.wr_addr = idx_reg[krt_pkg::ADDR_W-1:0];
        mem_req.wr_key  = key_reg;
        mem_req.wr_val  = val_reg;
        div_req.start    = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = count_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = in_op;
                    key_next  = req.key;
                    val_next  = req.value;
                    idx_next  = '0;
                    sum_next  = '0;
                    held_next = 1'b0;
                    if ((in_op == krt_pkg::REQ_INSERT) && table_full)
                    begin
                        st_status_next = krt_pkg::ST_FULL;
                        st_idx_next    = '0;
                        st_key_next    = '0;
                        st_val_next    = '0;
                        state_next     = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end

            S_FETCH:
            begin
                state_next = S_TEST;
            end

            S_TEST:
            begin
                mem_req.rd_addr = idx_inc[krt_pkg::ADDR_W-1:0];
                if (op_reg == krt_pkg::REQ_AVERAGE)
                begin
                    if (scan_end)
                    begin
                        if (count_reg == '0)
                        begin
                            st_status_next = krt_pkg::ST_NONE;
                            st_idx_next    = '0;
                            st_key_next    = '0;
                            st_val_next    = '0;
                            state_next     = S_REPLY;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIVIDE;
                        end
                    end
                    else
                    begin
                        sum_next = sum_reg + krt_pkg::SUM_W'(mem_rdata.value);
                        idx_next = idx_inc;
                    end
                end
                else if (is_list)
                begin
                    if (scan_end)
                    begin
                        if (!held_reg)
                        begin
                            st_status_next = krt_pkg::ST_NONE;
                            st_idx_next    = '0;
                            st_key_next    = '0;
                            st_val_next    = '0;
                        end
                        state_next = S_REPLY;
                    end
                    else if (list_hit && held_reg && !out_free)
                    begin
                        // hold the read on this entry until the output frees
                        mem_req.rd_addr = idx_reg[krt_pkg::ADDR_W-1:0];
                    end
                    else
                    begin
                        if (list_hit)
                        begin
                            // a newer hit proves the staged one is not the last
                            emit           = held_reg;
                            held_next      = 1'b1;
                            st_status_next = krt_pkg::ST_OK;
                            st_idx_next    = krt_pkg::ENTRY_W'(idx_reg);
                            st_key_next    = mem_rdata.key;
                            st_val_next    = mem_rdata.value;
                        end
                        idx_next = idx_inc;
                    end
                end
                else
                begin
                    if (scan_end)
                    begin
                        if (op_reg == krt_pkg::REQ_INSERT)
                        begin
                            mem_req.we      = 1'b1;
                            mem_req.wr_addr = count_reg[krt_pkg::ADDR_W-1:0];
                            count_next      = count_reg + krt_pkg::CNT_W'(1);
                            st_status_next  = krt_pkg::ST_OK;
                            st_idx_next     = krt_pkg::ENTRY_W'(count_reg);
                            st_key_next     = key_reg;
                            st_val_next     = val_reg;
                        end
                        else
                        begin
                            st_status_next = krt_pkg::ST_NOTFOUND;
                            st_idx_next    = '0;
                            st_key_next    = '0;
                            st_val_next    = '0;
                        end
                        state_next = S_REPLY;
                    end
                    else if (key_hit)
                    begin
                        st_status_next = krt_pkg::ST_OK;
                        st_idx_next    = krt_pkg::ENTRY_W'(idx_reg);
                        st_key_next    = key_reg;
                        st_val_next    = mem_rdata.value;
                        state_next     = S_REPLY;
                        case (op_reg)
                            krt_pkg::REQ_INSERT:
                            begin
                                st_status_next = krt_pkg::ST_DUP;
                                st_idx_next    = '0;
                                st_key_next    = '0;
                                st_val_next    = '0;
                            end
                            krt_pkg::REQ_UPDATE:
                            begin
                                mem_req.we  = 1'b1;
                                st_val_next = val_reg;
                            end
                            krt_pkg::REQ_REMOVE:
                            begin
                                state_next = S_SHIFT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    else
                    begin
                        idx_next = idx_inc;
                    end
                end
            end

            S_SHIFT:
            begin
                // read data holds the entry one above the write slot
                mem_req.rd_addr = idx_inc2[krt_pkg::ADDR_W-1:0];
                if (idx_inc < count_reg)
                begin
                    mem_req.we     = 1'b1;
                    mem_req.wr_key = mem_rdata.key;
                    mem_req.wr_val = mem_rdata.value;
                    idx_next       = idx_inc;
                end
                else
                begin
                    count_next = count_reg - krt_pkg::CNT_W'(1);
                    state_next = S_REPLY;
                end
            end

            S_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    st_status_next = krt_pkg::ST_OK;
                    st_idx_next    = '0;
                    st_key_next    = '0;
                    st_val_next    = div_rsp.quotient[krt_pkg::VAL_W-1:0];
                    state_next     = S_REPLY;
                end
            end

            S_REPLY:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_key_next    = out_key_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = st_status_reg;
            out_idx_next    = st_idx_reg;
            out_key_next    = st_key_reg;
            out_val_next    = st_val_reg;
            out_last_next   = emit_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            held_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        st_status_reg  <= st_status_next;
        st_idx_reg     <= st_idx_next;
        st_key_reg     <= st_key_next;
        st_val_reg     <= st_val_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_key_reg    <= out_key_next;
        out_val_reg    <= out_val_next;
        out_last_reg   <= out_last_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.entry_index  = out_idx_reg;
    assign rsp.result_key   = out_key_reg;
    assign rsp.result_value = out_val_reg;
    assign rsp.last         = out_last_reg;

endmodule

// ===== hdl/krt_checker.sv =====
// port-level checks for the keyed record table, bound to the top level
module krt_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [krt_pkg::STATUS_W-1:0]    status,
    input logic [krt_pkg::ENTRY_W-1:0]     entry_index,
    input logic [krt_pkg::KEY_W-1:0]       result_key,
    input logic [krt_pkg::VAL_W-1:0]       result_value,
    input logic                            last
);

    // a waiting result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_index)
        && $stable(result_key) && $stable(result_value) && $stable(last))
        else $error("result changed while stalled");

    // no new item while a list is still being reported
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> !req_ready)
        else $error("ready during an unfinished list");

    // ready is low in the cycle after an item is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready straight after accepting an item");

    // error results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != krt_pkg::ST_OK) |->
        (entry_index == '0) && (result_key == '0) && (result_value == '0) && last)
        else $error("error result with non-zero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= krt_pkg::ST_NONE))
        else $error("status code out of range");

endmodule

bind keyed_record_table_top krt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .status       (rsp.status),
    .entry_index  (rsp.entry_index),
    .result_key   (rsp.result_key),
    .result_value (rsp.result_value),
    .last         (rsp.last)
);
